// ----- src/crs_pkg.sv -----
`default_nettype none
package crs_pkg;
  localparam int MaxGrid = 32;
  localparam int IdxW = $clog2(MaxGrid);
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = MaxGrid * MaxGrid;
  localparam int CntW = AddrW + 1;
  localparam int AccW = 48;
  localparam int MulW = AccW + 17;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_WRITE_RD, ST_WRITE_WB, ST_SPLIT, ST_FETCH,
    ST_COEF, ST_HORNER, ST_HALF, ST_DONE
  } state_e;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_EVAL  = 1'b1
  } mode_e;

  typedef struct packed {
    logic              start;
    logic signed [AccW-1:0] p0, p1, p2, p3;
    logic [16:0]       t;
  } cub_req_t;

  function automatic logic [IdxW-1:0] clamp_idx(input logic signed [IdxW+1:0] x,
                                                input logic [IdxW:0] n);
    logic signed [IdxW+1:0] hi;
    hi = $signed({1'b0, n}) - (IdxW+2)'(1);
    if (x < 0) return '0;
    if (x > hi) return hi[IdxW-1:0];
    return x[IdxW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- src/crs_grid_mem.sv -----
`default_nettype none
module crs_grid_mem import crs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [31:0]       wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic [31:0]            rdata_o
);
  logic [31:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/crs_cubic.sv -----
`default_nettype none
// Catmull-Rom cubic via shared multiplier, one Horner step per cycle.
module crs_cubic import crs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cub_req_t          req_i,
  output logic                   done_o,
  output logic signed [AccW-1:0] res_o
);
  logic signed [AccW-1:0] h_q, h_d, a_q, b_q, p1_q;
  logic [16:0] t_q;
  logic [2:0] step_q, step_d;
  logic signed [MulW-1:0] prod;
  logic signed [MulW-1:0] rnd;
  logic signed [AccW-1:0] sh;
  logic signed [AccW:0] fin;

  assign prod = h_q * $signed({1'b0, t_q});
  assign rnd  = prod + MulW'(32768);
  assign sh   = AccW'(rnd >>> 16);
  assign fin  = ({h_q[AccW-1], h_q} + 1) >>> 1;

  always_comb begin
    h_d = h_q;
    step_d = step_q;
    unique case (step_q)
      3'd1: begin h_d = b_q + sh; step_d = 3'd2; end
      3'd2: begin h_d = a_q + sh; step_d = 3'd3; end
      3'd3: begin h_d = (p1_q <<< 1) + sh; step_d = 3'd4; end
      3'd4: step_d = 3'd0;
      default: step_d = 3'd0;
    endcase
    if (req_i.start) begin
      h_d = -req_i.p0 + 3 * req_i.p1 - 3 * req_i.p2 + req_i.p3;
      step_d = 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= '0;
    else step_q <= step_d;
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (req_i.start) begin
      a_q  <= req_i.p2 - req_i.p0;
      b_q  <= 2 * req_i.p0 - 5 * req_i.p1 + 4 * req_i.p2 - req_i.p3;
      p1_q <= req_i.p1;
      t_q  <= req_i.t;
    end
  end

  assign done_o = (step_q == 3'd4);
  assign res_o  = fin[AccW-1:0];
endmodule
`default_nettype wire

// ----- src/catmull_rom_surface_eval_top.sv -----
`default_nettype none
// Bicubic Catmull-Rom surface evaluator over a 32x32 height grid, one word at a time.
// Write words pass through accept, read and write back. Evaluate words pass through
// split, fetch (16 reads through one port), five cubic passes through one shared
// multiplier, halve and hand-off; a flat grid goes from split straight to hand-off.
// Reset: clearing pass over all 1024 grid words, no word accepted meanwhile;
// grid_size resets to 5 and the nonzero count to 0.
module catmull_rom_surface_eval_top import crs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: col_index[4:0], row_index[9:5], point_height[41:10], u_pos[58:42],
  //        v_pos[75:59], zero pad to 80
  input  wire logic [79:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // height[31:0]
  output logic             m_axis_tuser    // grid_flat
);
  state_e st_q, st_d;
  logic [5:0] gsize_q;
  logic [CntW-1:0] nz_q;
  logic [AddrW-1:0] clr_q;
  logic [79:0] in_q;
  logic [IdxW:0] n;
  logic [IdxW-1:0] iu_q, iv_q;
  logic [16:0] tu_q, tv_q;
  logic [3:0] fc_q;        // fetch counter 0..15
  logic       fvld_q;      // a read is in flight
  logic [3:0] wc_q;        // landed word index
  logic signed [AccW-1:0] pt_q [4];
  logic signed [AccW-1:0] col_q [4];
  logic [2:0] row_q;       // cubic pass number 0..4 (5 after the last)
  logic busy_q;
  logic signed [31:0] res_q;
  logic flat_q;
  logic [31:0] out_hgt_q;  // output word, decoupled from the working result
  logic out_flat_q;
  logic hand_off;          // move the finished result into the output register

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  crs_grid_mem u_mem (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  cub_req_t req;
  logic cdone;
  logic signed [AccW-1:0] cres;
  crs_cubic u_cub (.clk_i, .rst_ni, .req_i(req), .done_o(cdone), .res_o(cres));

  logic [4:0] wcol, wrow;
  logic [31:0] whgt;
  assign wcol = in_q[4:0];
  assign wrow = in_q[9:5];
  assign whgt = in_q[41:10];

  assign n = (gsize_q < 6'd2) ? (IdxW+1)'(2) :
             (gsize_q > 6'(MaxGrid)) ? (IdxW+1)'(MaxGrid) : (IdxW+1)'(gsize_q);

  // split: scale by n-1; product fits 17+5 bits
  logic [16:0] up, vp;
  logic [22:0] fu, fv;
  logic [IdxW:0] ciu, civ, nm2;
  assign up  = (in_q[58:42] > 17'd65536) ? 17'd65536 : in_q[58:42];
  assign vp  = (in_q[75:59] > 17'd65536) ? 17'd65536 : in_q[75:59];
  assign fu  = up * 23'(n - 1);
  assign fv  = vp * 23'(n - 1);
  assign nm2 = n - (IdxW+1)'(2);
  assign ciu = ((IdxW+1)'(fu[22:16]) > nm2) ? nm2 : (IdxW+1)'(fu[22:16]);
  assign civ = ((IdxW+1)'(fv[22:16]) > nm2) ? nm2 : (IdxW+1)'(fv[22:16]);

  // fetch address: row iv-1+fc[3:2], col iu-1+fc[1:0], edge clamped
  logic [IdxW-1:0] fcol, frow;
  assign fcol = clamp_idx($signed({2'b0, iu_q}) + $signed({5'b0, fc_q[1:0]}) - 7'sd1, n);
  assign frow = clamp_idx($signed({2'b0, iv_q}) + $signed({5'b0, fc_q[3:2]}) - 7'sd1, n);

  // hold the finished result until the output register is free
  assign hand_off = (st_q == ST_DONE) && (!busy_q || m_axis_tready);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR:    if (clr_q == '1) st_d = ST_IDLE;
      ST_IDLE:     if (s_axis_tvalid && s_axis_tready)
                     st_d = s_axis_tuser == MODE_EVAL ? ST_SPLIT : ST_WRITE_RD;
      ST_WRITE_RD: st_d = ST_WRITE_WB;
      ST_WRITE_WB: st_d = ST_IDLE;
      ST_SPLIT:    st_d = (nz_q == '0) ? ST_DONE : ST_FETCH;
      ST_FETCH:    if (fvld_q && wc_q == 4'd15) st_d = ST_COEF;
      ST_COEF:     st_d = ST_HORNER;
      ST_HORNER:   if (cdone) st_d = (row_q == 3'd4) ? ST_HALF : ST_COEF;
      ST_HALF:     st_d = ST_DONE;
      ST_DONE:     if (hand_off) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = {wrow, wcol};
    wdata = whgt;
    raddr = {wrow, wcol};
    unique case (st_q)
      ST_CLEAR: begin we = 1'b1; waddr = clr_q; wdata = '0; end
      ST_WRITE_WB: we = 1'b1;
      ST_FETCH: raddr = {frow, fcol};
      default: ;
    endcase
    req.start = (st_q == ST_COEF);
    req.t  = (row_q == 3'd4) ? tv_q : tu_q;
    req.p0 = (row_q == 3'd4) ? col_q[0] : pt_q[0];
    req.p1 = (row_q == 3'd4) ? col_q[1] : pt_q[1];
    req.p2 = (row_q == 3'd4) ? col_q[2] : pt_q[2];
    req.p3 = (row_q == 3'd4) ? col_q[3] : pt_q[3];
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = out_hgt_q;
  assign m_axis_tuser  = out_flat_q;

  // row points buffered in 16 regs? Only 4 per pass: hold all 16 landed words
  logic signed [31:0] win_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; gsize_q <= 6'd5; nz_q <= '0; clr_q <= '0;
      busy_q <= 1'b0; fc_q <= '0; fvld_q <= 1'b0; wc_q <= '0; row_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) gsize_q <= cfg_wdata_i;
      if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (busy_q && m_axis_tready) busy_q <= 1'b0;
      if (hand_off) busy_q <= 1'b1;
      if (st_q == ST_WRITE_WB) begin
        if (rdata != 0 && whgt == 0) nz_q <= nz_q - 1'b1;
        else if (rdata == 0 && whgt != 0) nz_q <= nz_q + 1'b1;
      end
      if (st_q == ST_SPLIT) begin fc_q <= '0; fvld_q <= 1'b0; wc_q <= '0; row_q <= '0; end
      if (st_q == ST_FETCH) begin
        fvld_q <= 1'b1;
        wc_q <= fc_q;
        if (fc_q != 4'd15) fc_q <= fc_q + 1'b1;
      end
      if (st_q == ST_HORNER && cdone) row_q <= row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
    if (st_q == ST_SPLIT) begin
      iu_q <= ciu[IdxW-1:0]; iv_q <= civ[IdxW-1:0];
      tu_q <= 17'(fu - {ciu, 16'b0});
      tv_q <= 17'(fv - {civ, 16'b0});
      res_q <= '0; flat_q <= (nz_q == '0);
    end
    if (st_q == ST_FETCH && fvld_q) win_q[wc_q] <= rdata;
    if (st_q == ST_COEF && row_q != 3'd4) begin
      for (int k = 0; k < 4; k++) pt_q[k] <= AccW'(win_q[{row_q[1:0], 2'(k)}]);
    end
    // load the first row as the last word lands, so COEF sees it
    if (st_q == ST_FETCH && fvld_q && wc_q == 4'd15) begin
      for (int k = 0; k < 4; k++) pt_q[k] <= AccW'(win_q[k]);
    end
    if (st_q == ST_HORNER && cdone) begin
      if (row_q != 3'd4) begin
        col_q[row_q[1:0]] <= cres;
        if (row_q != 3'd3) begin
          for (int k = 0; k < 4; k++)
            pt_q[k] <= AccW'(win_q[{2'(row_q[1:0] + 2'd1), 2'(k)}]);
        end
      end else begin
        res_q <= (cres > 48'sd2147483647) ? 32'sh7fffffff :
                 (cres < -48'sd2147483648) ? 32'sh80000000 : cres[31:0];
      end
    end
    if (hand_off) begin
      out_hgt_q  <= res_q;
      out_flat_q <= flat_q;
    end
  end
endmodule
`default_nettype wire

// ----- tb/crs_checker.sv -----
`timescale 1ns / 1ps
module crs_checker import crs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [79:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic        m_tuser,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic signed [31:0] height;
    logic               flat;
  } surf_t;

  logic signed [31:0] heights [Depth];
  int unsigned        nz_cnt;
  logic [5:0]         gsize;
  surf_t              expected_q [$];

  assign pending = expected_q.size();

  function automatic longint rnd16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint cr_cubic(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
    longint a, b, c, h;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    h = b + rnd16(c * t);
    h = a + rnd16(h * t);
    h = 2 * p1 + rnd16(h * t);
    return (h + 1) >>> 1;
  endfunction

  function automatic int clampi(int x, int lo, int hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint height_at(int c, int r, int n);
    return longint'(heights[clampi(r, 0, n - 1) * MaxGrid + clampi(c, 0, n - 1)]);
  endfunction

  function automatic surf_t eval_surface(logic [16:0] up, logic [16:0] vp);
    surf_t  s;
    int     n, iu, iv;
    longint f, tu, tv, rowv[4], r;
    s.flat = 1'b0;
    if (nz_cnt == 0) begin
      s.height = '0;
      s.flat = 1'b1;
      return s;
    end
    n = clampi(int'(gsize), 2, MaxGrid);
    f = longint'(up > 17'd65536 ? 17'd65536 : up) * (n - 1);
    iu = clampi(int'(f >>> 16), 0, n - 2);
    tu = f - (longint'(iu) << 16);
    f = longint'(vp > 17'd65536 ? 17'd65536 : vp) * (n - 1);
    iv = clampi(int'(f >>> 16), 0, n - 2);
    tv = f - (longint'(iv) << 16);
    for (int k = 0; k < 4; k++)
      rowv[k] = cr_cubic(height_at(iu - 1, iv - 1 + k, n), height_at(iu, iv - 1 + k, n),
                         height_at(iu + 1, iv - 1 + k, n), height_at(iu + 2, iv - 1 + k, n),
                         tu);
    r = cr_cubic(rowv[0], rowv[1], rowv[2], rowv[3], tv);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    s.height = r[31:0];
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    surf_t got, want;
    int    idx;
    if (!rst_ni) begin
      foreach (heights[i]) heights[i] = '0;
      nz_cnt = 0;
      gsize = 6'd5;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) gsize = cfg_wdata_i;
      if (m_tvalid && m_tready) begin
        got.height = m_tdata;
        got.flat = m_tuser;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: %h flat %0b", m_tdata, m_tuser);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: height exp %0d got %0d, flat exp %0b got %0b",
                       want.height, got.height, want.flat, got.flat);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (mode_e'(s_tuser) == MODE_WRITE) begin
          idx = int'(s_tdata[9:5]) * MaxGrid + int'(s_tdata[4:0]);
          if (heights[idx] != 0 && s_tdata[41:10] == 0) nz_cnt--;
          else if (heights[idx] == 0 && s_tdata[41:10] != 0) nz_cnt++;
          heights[idx] = s_tdata[41:10];
        end else begin
          expected_q.push_back(eval_surface(s_tdata[58:42], s_tdata[75:59]));
        end
      end
    end
  end
endmodule

// ----- tb/tb_catmull_rom_surface_eval_top.sv -----
`timescale 1ns / 1ps
module tb_catmull_rom_surface_eval_top;
  import crs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending;
  int          stall_cycles = 0;
  bit          timed_out = 1'b0;
  bit          pace_off = 1'b0;

  localparam int WatchdogLimit = 20000;

  always #5 clk_i = ~clk_i;

  catmull_rom_surface_eval_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  crs_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .m_tuser(m_axis_tuser),
    .fail_count, .pending
  );

  // Receiver: random stalls, mostly 60% ready, now and then a random 10-100% duty; never with pace_off.
  always @(posedge clk_i) begin
    int pct;
    pct = pace_off ? 100 : (($urandom_range(0, 99) < 3) ? $urandom_range(10, 100) : -1);
    if (pace_off || pct < 0)
      m_axis_tready <= ($urandom_range(0, 99) < 60) || pace_off;
    else
      m_axis_tready <= $urandom_range(0, 99) < pct;
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else if (rst_ni)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_catmull_rom_surface_eval_top failed");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one word and hold it until accepted; bursts with random gaps between.
  task automatic send_word(mode_e md, logic [4:0] col, logic [4:0] row,
                           logic [31:0] hgt, logic [16:0] up, logic [16:0] vp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= md;
    s_axis_tdata <= {4'b0, vp, up, hgt, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    // drop valid for one cycle; the block cannot take a word right after one anyway
    @(posedge clk_i);
  endtask

  task automatic write_point(int col, int row, logic [31:0] hgt);
    send_word(MODE_WRITE, col[4:0], row[4:0], hgt, 17'($urandom), 17'($urandom));
  endtask

  task automatic eval_at(logic [16:0] up, logic [16:0] vp);
    send_word(MODE_EVAL, 5'($urandom), 5'($urandom), $urandom, up, vp);
  endtask

  // Drain results, then allow the block to finish any trailing write.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [5:0] gs);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= gs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [16:0] rand_param();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 17'd0;
    if (sel == 1) return 17'd65536;
    if (sel == 2) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] rand_height();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'h7fffffff;
    if (sel == 2) return 32'h80000000;
    if (sel < 6) return $urandom;
    return 32'($signed($urandom_range(0, 2000000)) - 1000000);
  endfunction

  initial begin
    logic [5:0] sizes [6];
    int gs;
    sizes = '{6'd0, 6'd2, 6'd32, 6'd63, 6'd9, 6'd17};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: flat grid, then extremes, edges and out-of-range parameters.
    eval_at(17'd0, 17'd0);
    write_point(0, 0, 32'h7fffffff);
    write_point(4, 4, 32'h80000000);
    write_point(31, 31, 32'hffffffff);
    write_point(2, 1, 32'h00010000);
    eval_at(17'd0, 17'd0);
    eval_at(17'd65536, 17'd65536);
    eval_at(17'h1ffff, 17'd32768);
    eval_at(17'd32768, 17'd65535);
    write_point(0, 0, 32'h0);
    write_point(4, 4, 32'h0);
    write_point(2, 1, 32'h0);
    eval_at(17'd100, 17'd200);
    write_point(31, 31, 32'h0);
    eval_at(17'd65536, 17'd0);
    // Hold off until every expected result has arrived.
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      set_grid(sizes[ph]);
      gs = (sizes[ph] < 2) ? 2 : (sizes[ph] > 32 ? 32 : sizes[ph]);
      pace_off = (ph == 3);
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 9) == 0)
            write_point($urandom_range(0, 31), $urandom_range(0, 31), rand_height());
          else
            write_point($urandom_range(0, gs - 1), $urandom_range(0, gs - 1),
                        rand_height());
        end else begin
          eval_at(rand_param(), rand_param());
        end
      end
      // In phase 2, clear the whole grid back to flat and evaluate once.
      if (ph == 2)
        for (int r = 0; r < 32; r++)
          for (int c = 0; c < 32; c++) write_point(c, r, 32'h0);
      if (ph == 2) eval_at(17'd40000, 17'd40000);
    end

    wait_idle();
    if (fail_count == 0)
      $display("tb_catmull_rom_surface_eval_top passed");
    else
      $display("tb_catmull_rom_surface_eval_top failed");
    $finish;
  end
endmodule

// ----- sim.f -----
src/crs_pkg.sv
src/crs_grid_mem.sv
src/crs_cubic.sv
src/catmull_rom_surface_eval_top.sv
tb/crs_checker.sv
tb/tb_catmull_rom_surface_eval_top.sv
